@@ hw/rtl/kbgp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kbgp_pkg: shared types and helpers for keyboard report to gamepad state
// Key map, event and stick map types, and the saturating stick step.
// ----------------------------------------------------------------------------
package kbgp_pkg;

    localparam int KEY_SLOTS    = 6;
    localparam int CODE_W       = 8;
    localparam int STICK_W      = 12;
    localparam int EVENTS       = 2 * KEY_SLOTS;
    localparam int EV_PER_STAGE = 4;
    localparam int COMP_STAGES  = (EVENTS + EV_PER_STAGE - 1) / EV_PER_STAGE;
    localparam int FRONT_STAGES = COMP_STAGES + 1;
    localparam int D_W          = $clog2(EVENTS * (2 ** STICK_W)) + 1;
    localparam int BTN_BYTES    = 3;
    localparam int BTN_W        = BTN_BYTES * 8;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [STICK_W-1:0] STICK_MAX   = '1;
    localparam logic [STICK_W-1:0] STICK_RESET = STICK_W'(2047);

    // hid usage codes
    localparam logic [CODE_W-1:0] KEY_CODE_Y     = 8'h1C;
    localparam logic [CODE_W-1:0] KEY_CODE_X     = 8'h1B;
    localparam logic [CODE_W-1:0] KEY_CODE_SPACE = 8'h2C;
    localparam logic [CODE_W-1:0] KEY_CODE_E     = 8'h08;
    localparam logic [CODE_W-1:0] KEY_CODE_R     = 8'h15;
    localparam logic [CODE_W-1:0] KEY_CODE_Z     = 8'h1D;
    localparam logic [CODE_W-1:0] KEY_CODE_P     = 8'h13;
    localparam logic [CODE_W-1:0] KEY_CODE_Q     = 8'h14;
    localparam logic [CODE_W-1:0] KEY_CODE_W     = 8'h1A;
    localparam logic [CODE_W-1:0] KEY_CODE_S     = 8'h16;
    localparam logic [CODE_W-1:0] KEY_CODE_A     = 8'h04;
    localparam logic [CODE_W-1:0] KEY_CODE_D     = 8'h07;
    localparam logic [CODE_W-1:0] KEY_CODE_NONE  = 8'h00;

    typedef enum logic [1:0] {
        GRP_BYTE0,
        GRP_BYTE1,
        GRP_BYTE2,
        GRP_STICK
    } key_grp_t;

    typedef struct packed {
        logic     hit;
        key_grp_t grp;
        logic [2:0] bitn;
        logic     vert;   // stick key moves the vertical axis
        logic     up;     // press increases the axis
    } key_info_t;

    // composite of a run of saturating moves: x -> clamp(x + d, lo, hi)
    typedef struct packed {
        logic [STICK_W-1:0]    lo;
        logic [STICK_W-1:0]    hi;
        logic signed [D_W-1:0] d;
    } axis_map_t;

    typedef struct packed {
        logic [EVENTS-1:0] mv;
        logic [EVENTS-1:0] up;
    } axis_ev_t;

    typedef struct packed {
        logic [BTN_W-1:0] set;
        logic [BTN_W-1:0] touch;
        axis_map_t        h;
        axis_map_t        v;
    } cmd_t;

    typedef struct packed {
        cmd_t     cmd;
        axis_ev_t ev_h;
        axis_ev_t ev_v;
    } front_st_t;

    function automatic key_info_t key_lookup(input logic [CODE_W-1:0] code);
        key_info_t k;
        k = '0;
        k.hit = 1'b1;
        unique case (code)
            KEY_CODE_Y:     begin k.grp = GRP_BYTE0; k.bitn = 3'd0; end
            KEY_CODE_X:     begin k.grp = GRP_BYTE0; k.bitn = 3'd1; end
            KEY_CODE_SPACE: begin k.grp = GRP_BYTE0; k.bitn = 3'd2; end
            KEY_CODE_E:     begin k.grp = GRP_BYTE0; k.bitn = 3'd3; end
            KEY_CODE_R:     begin k.grp = GRP_BYTE0; k.bitn = 3'd6; end
            KEY_CODE_Z:     begin k.grp = GRP_BYTE0; k.bitn = 3'd7; end
            KEY_CODE_P:     begin k.grp = GRP_BYTE1; k.bitn = 3'd1; end
            KEY_CODE_Q:     begin k.grp = GRP_BYTE2; k.bitn = 3'd7; end
            KEY_CODE_W:     begin k.grp = GRP_STICK; k.vert = 1'b1; k.up = 1'b1; end
            KEY_CODE_S:     begin k.grp = GRP_STICK; k.vert = 1'b1; k.up = 1'b0; end
            KEY_CODE_A:     begin k.grp = GRP_STICK; k.vert = 1'b0; k.up = 1'b0; end
            KEY_CODE_D:     begin k.grp = GRP_STICK; k.vert = 1'b0; k.up = 1'b1; end
            default:        k.hit = 1'b0;
        endcase
        return k;
    endfunction

    function automatic logic [STICK_W-1:0] sat_move(input logic [STICK_W-1:0] x,
                                                    input logic up,
                                                    input logic [STICK_W-1:0] s);
        logic [STICK_W:0] sum;
        logic [STICK_W-1:0] r;
        sum = {1'b0, x} + {1'b0, s};
        if (up)
        begin
            r = sum[STICK_W] ? STICK_MAX : sum[STICK_W-1:0];
        end
        else
        begin
            r = (s > x) ? '0 : x - s;
        end
        return r;
    endfunction

    // append one move to a composite map
    function automatic axis_map_t axis_step(input axis_map_t m, input logic up,
                                            input logic [STICK_W-1:0] s);
        axis_map_t r;
        logic signed [D_W-1:0] sx;
        sx   = signed'({{(D_W-STICK_W){1'b0}}, s});
        r.lo = sat_move(m.lo, up, s);
        r.hi = sat_move(m.hi, up, s);
        r.d  = up ? m.d + sx : m.d - sx;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/kbgp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kbgp_front: report classification and stick move composition
// Finds presses and releases against the previous report, builds button
// masks, then folds the ordered stick moves into clamp maps over a pipeline.
// ----------------------------------------------------------------------------
module kbgp_front (
    input  wire logic                                             clk,
    input  wire logic                                             rst_n,
    input  wire logic                                             in_valid,
    output logic                                                  in_stall,
    input  wire logic [kbgp_pkg::KEY_SLOTS-1:0][kbgp_pkg::CODE_W-1:0] keys,
    input  wire logic [kbgp_pkg::STICK_W-1:0]                     stick_step,
    output logic                                                  push_valid,
    output kbgp_pkg::cmd_t                                        push_data,
    input  wire logic                                             push_ready
);
    import kbgp_pkg::*;

    logic [KEY_SLOTS-1:0][CODE_W-1:0] prev_reg;
    logic [FRONT_STAGES-1:0]          vld_reg;
    logic [FRONT_STAGES:0]            rdy;
    front_st_t                        st_reg  [FRONT_STAGES];
    front_st_t                        st_next [FRONT_STAGES];
    logic                             accept;

    always_comb
    begin
        rdy[FRONT_STAGES] = push_ready;
        for (int k = FRONT_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_stall   = !rdy[0];
    assign accept     = in_valid && rdy[0];
    assign push_valid = vld_reg[FRONT_STAGES-1];
    assign push_data  = st_reg[FRONT_STAGES-1].cmd;

    // classification: press of current slot first, then release of previous
    always_comb
    begin
        key_info_t ki;
        logic      in_prev;
        logic      in_cur;
        ki                  = '0;
        in_prev             = 1'b0;
        in_cur              = 1'b0;
        st_next[0]          = '0;
        st_next[0].cmd.h.hi = STICK_MAX;
        st_next[0].cmd.v.hi = STICK_MAX;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            in_prev = 1'b0;
            in_cur  = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                if (prev_reg[j] == keys[i])
                begin
                    in_prev = 1'b1;
                end
                if (keys[j] == prev_reg[i])
                begin
                    in_cur = 1'b1;
                end
            end
            if (keys[i] != KEY_CODE_NONE && !in_prev)
            begin
                ki = key_lookup(keys[i]);
                if (ki.hit && ki.grp == GRP_STICK)
                begin
                    if (ki.vert)
                    begin
                        st_next[0].ev_v.mv[2*i] = 1'b1;
                        st_next[0].ev_v.up[2*i] = ki.up;
                    end
                    else
                    begin
                        st_next[0].ev_h.mv[2*i] = 1'b1;
                        st_next[0].ev_h.up[2*i] = ki.up;
                    end
                end
                else if (ki.hit)
                begin
                    st_next[0].cmd.touch[{ki.grp, ki.bitn}] = 1'b1;
                    st_next[0].cmd.set[{ki.grp, ki.bitn}]   = 1'b1;
                end
            end
            if (prev_reg[i] != KEY_CODE_NONE && !in_cur)
            begin
                ki = key_lookup(prev_reg[i]);
                if (ki.hit && ki.grp == GRP_STICK)
                begin
                    if (ki.vert)
                    begin
                        st_next[0].ev_v.mv[2*i+1] = 1'b1;
                        st_next[0].ev_v.up[2*i+1] = !ki.up;
                    end
                    else
                    begin
                        st_next[0].ev_h.mv[2*i+1] = 1'b1;
                        st_next[0].ev_h.up[2*i+1] = !ki.up;
                    end
                end
                else if (ki.hit)
                begin
                    st_next[0].cmd.touch[{ki.grp, ki.bitn}] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            vld_reg[0] <= 1'b0;
        end
        else if (rdy[0])
        begin
            vld_reg[0] <= in_valid;
            if (in_valid)
            begin
                prev_reg <= keys;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg[0] <= st_next[0];
        end
    end

    // each stage folds a few moves into the running clamp maps
    for (genvar k = 1; k < FRONT_STAGES; k++)
    begin : g_comp
        always_comb
        begin
            front_st_t t;
            t = st_reg[k-1];
            for (int e = 0; e < EV_PER_STAGE; e++)
            begin
                if ((k - 1) * EV_PER_STAGE + e < EVENTS)
                begin
                    if (t.ev_h.mv[(k-1)*EV_PER_STAGE+e])
                    begin
                        t.cmd.h = axis_step(t.cmd.h, t.ev_h.up[(k-1)*EV_PER_STAGE+e],
                                            stick_step);
                    end
                    if (t.ev_v.mv[(k-1)*EV_PER_STAGE+e])
                    begin
                        t.cmd.v = axis_step(t.cmd.v, t.ev_v.up[(k-1)*EV_PER_STAGE+e],
                                            stick_step);
                    end
                end
            end
            st_next[k] = t;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && vld_reg[k-1])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/kbgp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kbgp_queue: short command queue between front and back
// Register based fifo that lets each side stall on its own.
// ----------------------------------------------------------------------------
module kbgp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire kbgp_pkg::cmd_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output kbgp_pkg::cmd_t      pop_data
);
    import kbgp_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = cnt_reg != Q_CNT_W'(Q_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/kbgp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kbgp_back: gamepad state update
// Applies button masks and stick clamp maps to the held state; the state
// registers double as the output register.
// ----------------------------------------------------------------------------
module kbgp_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             pop_valid,
    output logic                                  pop_ready,
    input  wire kbgp_pkg::cmd_t                   pop_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [kbgp_pkg::BTN_W-1:0]            buttons,
    output logic [kbgp_pkg::STICK_W-1:0]          stick_h,
    output logic [kbgp_pkg::STICK_W-1:0]          stick_v
);
    import kbgp_pkg::*;

    logic                 out_valid_reg;
    logic [BTN_W-1:0]     btn_reg;
    logic [BTN_W-1:0]     btn_next;
    logic [STICK_W-1:0]   stick_h_reg;
    logic [STICK_W-1:0]   stick_h_next;
    logic [STICK_W-1:0]   stick_v_reg;
    logic [STICK_W-1:0]   stick_v_next;
    logic                 load;

    function automatic logic [STICK_W-1:0] axis_apply(input logic [STICK_W-1:0] x,
                                                      input axis_map_t m);
        logic signed [D_W:0] sum;
        logic signed [D_W:0] lo_s;
        logic signed [D_W:0] hi_s;
        logic [STICK_W-1:0]  r;
        sum  = signed'({{(D_W+1-STICK_W){1'b0}}, x}) + signed'({m.d[D_W-1], m.d});
        lo_s = signed'({{(D_W+1-STICK_W){1'b0}}, m.lo});
        hi_s = signed'({{(D_W+1-STICK_W){1'b0}}, m.hi});
        priority if (sum < lo_s)
        begin
            r = m.lo;
        end
        else if (sum > hi_s)
        begin
            r = m.hi;
        end
        else
        begin
            r = sum[STICK_W-1:0];
        end
        return r;
    endfunction

    assign load      = pop_valid && (!out_valid_reg || !out_stall);
    assign pop_ready = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign buttons   = btn_reg;
    assign stick_h   = stick_h_reg;
    assign stick_v   = stick_v_reg;

    always_comb
    begin
        btn_next     = (btn_reg & ~pop_data.touch) | (pop_data.set & pop_data.touch);
        stick_h_next = axis_apply(stick_h_reg, pop_data.h);
        stick_v_next = axis_apply(stick_v_reg, pop_data.v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            btn_reg       <= '0;
            stick_h_reg   <= STICK_RESET;
            stick_v_reg   <= STICK_RESET;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                btn_reg       <= btn_next;
                stick_h_reg   <= stick_h_next;
                stick_v_reg   <= stick_v_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/keyboard_report_to_gamepad_state_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyboard_report_to_gamepad_state_top: keyboard report to gamepad state
// Turns six-slot keyboard reports into gamepad button and stick bytes.
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid / in_stall carries one report (key_slot0..5) per
//   transaction; output channel out_valid / out_stall returns the three
//   button bytes and the packed stick for every report, in order.
//   cfg_valid / cfg_ready writes stick_step; cfg_ready is always high and
//   writes are expected only while no report is in flight.
//   an input transaction reaches out_valid through the classification stage,
//   three stick composition stages, the queue and the state registers.
//   throughput: one report per cycle when out_stall is low; each composition
//   stage folds four of the twelve ordered stick moves, and the state update
//   is a single add-and-clamp per axis, so nothing iterates per report.
//   reset: buttons clear, both stick axes and stick_step at 2047, previous
//   report empty, no output pending.
//   a stalled output holds its bytes; the four-entry queue and the front
//   pipeline fill, then in_stall rises.
// ----------------------------------------------------------------------------
module keyboard_report_to_gamepad_state_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  key_slot0,
    input  wire logic [7:0]  key_slot1,
    input  wire logic [7:0]  key_slot2,
    input  wire logic [7:0]  key_slot3,
    input  wire logic [7:0]  key_slot4,
    input  wire logic [7:0]  key_slot5,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       button_byte0,
    output logic [7:0]       button_byte1,
    output logic [7:0]       button_byte2,
    output logic [7:0]       stick_byte0,
    output logic [7:0]       stick_byte1,
    output logic [7:0]       stick_byte2,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data
);
    import kbgp_pkg::*;

    logic [STICK_W-1:0]               stick_step_reg;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] keys;
    logic                             q_push_valid;
    logic                             q_push_ready;
    cmd_t                             q_push_data;
    logic                             q_pop_valid;
    logic                             q_pop_ready;
    cmd_t                             q_pop_data;
    logic [BTN_W-1:0]                 buttons;
    logic [STICK_W-1:0]               stick_h;
    logic [STICK_W-1:0]               stick_v;

    assign keys = {key_slot5, key_slot4, key_slot3, key_slot2, key_slot1, key_slot0};
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_step_reg <= STICK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            stick_step_reg <= cfg_data;
        end
    end

    kbgp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .keys       (keys),
        .stick_step (stick_step_reg),
        .push_valid (q_push_valid),
        .push_data  (q_push_data),
        .push_ready (q_push_ready)
    );

    kbgp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    kbgp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .buttons   (buttons),
        .stick_h   (stick_h),
        .stick_v   (stick_v)
    );

    assign button_byte0 = buttons[7:0];
    assign button_byte1 = buttons[15:8];
    assign button_byte2 = buttons[23:16];
    assign stick_byte0  = stick_h[7:0];
    assign stick_byte1  = {stick_v[3:0], stick_h[11:8]};
    assign stick_byte2  = stick_v[11:4];

    // front holds its last stage while the queue is full
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push_valid && !q_push_ready) |=> (q_push_valid && $stable(q_push_data)))
        else $error("front output changed while queue full");

    // a result only appears after a queued command was taken
    a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_pop_valid && q_pop_ready))
        else $error("output valid without a queued command");

    // gamepad state moves only when the back takes a command
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop_valid && q_pop_ready) |=> ($stable(buttons) && $stable(stick_h)
                                           && $stable(stick_v)))
        else $error("gamepad state changed without a command");

endmodule
`default_nettype wire
